### hdl/tagged_next_fit_allocator_defines.svh
// ----------------------------------------------------------------------------
// tagged_next_fit_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef TAGGED_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define TAGGED_NEXT_FIT_ALLOCATOR_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define TNFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication into the following cycle.
`define TNFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tnfa_pkg.sv
// ----------------------------------------------------------------------------
// tnfa_pkg
// Result codes, hash constants, request kinds and config indices of the tagged next-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tnfa_pkg;

  typedef enum logic [2:0] {
    ST_ALLOCATED  = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_FREED      = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_OUT_RANGE  = 3'd4
  } status_e;

  localparam logic [31:0] HASH_MUL   = 32'h9e37_79b1;
  localparam int unsigned HASH_SHIFT = 16;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic CFG_KEY = 1'b0;
  localparam logic CFG_CAP = 1'b1;

endpackage

`default_nettype wire

### hdl/tagged_next_fit_allocator.sv
// ----------------------------------------------------------------------------
// tagged_next_fit_allocator
// Next-fit block allocator with tagged, keyed headers held in one header RAM.
// A walk reads, hashes and checks each header in turn; a failed next-fit
// walk restarts once at offset 0, and the header write-back and the result
// hand-off follow.
// One request is worked at a time; the header RAM port and the hash
// multiplier set the pace. The result sits in an output register.
// After reset, and after every pool_capacity write, a clearing pass over all
// POOL_BYTES entries rewrites the header RAM; no request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tagged_next_fit_allocator_defines.svh"

module tagged_next_fit_allocator #(
  parameter int unsigned POOL_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // request_size[12:0], release_offset[24:13],
                                          // random_tag[56:25], zero pad
  input  wire logic        s_axis_tuser,  // kind
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // status[2:0], data_offset[14:3], zero pad
);

  localparam int unsigned AW    = $clog2(POOL_BYTES);
  localparam int unsigned OW    = AW + 1;
  localparam int unsigned SW    = ((OW > 13) ? OW : 13) + 2;
  localparam int unsigned EW    = OW + 64;
  localparam int unsigned LIMIT = POOL_BYTES + 1;
  localparam int unsigned CW    = $clog2(LIMIT + 1);
  localparam int unsigned RSTCAP = (POOL_BYTES < 4096) ? POOL_BYTES : 4096;

  localparam logic [SW-1:0] HDR_S  = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] POOL_S = SW'(POOL_BYTES);
  localparam logic [OW-1:0] LAST_O = OW'(POOL_BYTES - 1);
  localparam logic [CW-1:0] LIM_C  = CW'(LIMIT);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_RD    = 10'b00_0000_0100,
    S_WAIT  = 10'b00_0000_1000,
    S_EVAL  = 10'b00_0001_0000,
    S_HASHN = 10'b00_0010_0000,
    S_WRA   = 10'b00_0100_0000,
    S_WRB   = 10'b00_1000_0000,
    S_MRGWR = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // header RAM: {end, tag, check}
  logic [EW-1:0] mem [POOL_BYTES];
  logic [EW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  logic [31:0]   key_q;
  logic [OW-1:0] cap_q, cap_d;
  logic [OW-1:0] search_q, search_d;
  logic [OW-1:0] clr_q, clr_d;
  logic          kind_q, kind_d;
  logic [12:0]   n_q, n_d;
  logic [31:0]   tag_q, tag_d;
  logic [OW-1:0] off_q, off_d;
  logic [OW-1:0] hdr_q, hdr_d;
  logic [OW-1:0] nend_q, nend_d;
  logic [OW-1:0] oend_q, oend_d;
  logic          split_q, split_d;
  logic [CW-1:0] steps_q, steps_d;
  logic          pass_q, pass_d;
  logic          merge_q, merge_d;
  logic [31:0]   chk_q, chk_d;
  logic [31:0]   prod_q, prod_d;
  logic [2:0]    status_q, status_d;
  logic [11:0]   data_q, data_d;
  logic          ovalid_q, ovalid_d;
  logic [15:0]   odata_q, odata_d;

  logic [OW-1:0] rd_end, end_sat;
  logic [31:0]   rd_tag, rd_chk, hash, hash_in;
  logic          in_use, in_fire, cap_wr;
  logic [SW-1:0] fit_sum, rel_s, cap_s, cfg_s;
  logic [OW-1:0] cap_clamp;

  assign rd_end  = rdata_q[EW-1:64];
  assign rd_tag  = rdata_q[63:32];
  assign rd_chk  = rdata_q[31:0];
  assign end_sat = (rd_end > cap_q) ? cap_q : rd_end;
  assign hash    = prod_q ^ (prod_q >> tnfa_pkg::HASH_SHIFT);
  assign in_use  = (rd_tag != 32'd0) && (hash == rd_chk);
  assign fit_sum = SW'(off_q) + HDR_S + SW'(n_q);
  assign rel_s   = SW'(s_axis_tdata[24:13]);
  assign cap_s   = SW'(cap_q);
  assign cfg_s   = SW'(cfg_data_i[12:0]);
  assign cap_clamp = (cfg_s < HDR_S) ? OW'(HEADER_BYTES) :
                     (cfg_s > POOL_S) ? OW'(POOL_BYTES) : OW'(cfg_s);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cap_wr  = cfg_we_i && (cfg_idx_i == tnfa_pkg::CFG_CAP);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  always_comb begin
    state_d  = state_q;
    cap_d    = cap_q;
    search_d = search_q;
    clr_d    = clr_q;
    kind_d   = kind_q;
    n_d      = n_q;
    tag_d    = tag_q;
    off_d    = off_q;
    hdr_d    = hdr_q;
    nend_d   = nend_q;
    oend_d   = oend_q;
    split_d  = split_q;
    steps_d  = steps_q;
    pass_d   = pass_q;
    merge_d  = merge_q;
    chk_d    = chk_q;
    prod_d   = prod_q;
    status_d = status_q;
    data_d   = data_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_q[AW-1:0];
    mem_raddr = off_q[AW-1:0];
    mem_wdata = '0;
    hash_in   = 32'(off_q) ^ rd_tag ^ key_q;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (clr_q == '0) ? {cap_q, 64'd0} : '0;
        if (clr_q == LAST_O) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + OW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          kind_d  = s_axis_tuser;
          n_d     = s_axis_tdata[12:0];
          tag_d   = s_axis_tdata[56:25];
          data_d  = 12'd0;
          steps_d = '0;
          pass_d  = 1'b0;
          merge_d = 1'b0;
          if (s_axis_tuser == tnfa_pkg::KIND_ALLOC) begin
            off_d   = search_q;
            state_d = S_RD;
          end else if (rel_s < HDR_S || rel_s >= cap_s) begin
            status_d = tnfa_pkg::ST_OUT_RANGE;
            state_d  = S_DONE;
          end else begin
            off_d   = OW'(rel_s - HDR_S);
            hdr_d   = OW'(rel_s - HDR_S);
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (kind_q == tnfa_pkg::KIND_ALLOC && (steps_q == LIM_C || off_q >= cap_q)) begin
          if (!pass_q) begin
            pass_d  = 1'b1;
            off_d   = '0;
            steps_d = '0;
          end else begin
            status_d = tnfa_pkg::ST_NO_SPACE;
            state_d  = S_DONE;
          end
        end else if (merge_q && (steps_q == LIM_C || off_q >= cap_q)) begin
          state_d = S_MRGWR;
        end else begin
          mem_re  = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        prod_d  = hash_in * tnfa_pkg::HASH_MUL;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (kind_q == tnfa_pkg::KIND_ALLOC) begin
          if (!in_use && SW'(end_sat) >= fit_sum) begin
            hdr_d   = off_q;
            oend_d  = end_sat;
            nend_d  = OW'(fit_sum);
            split_d = (SW'(end_sat) - fit_sum) >= HDR_S;
            data_d  = 12'(SW'(off_q) + HDR_S);
            state_d = S_HASHN;
          end else begin
            off_d   = end_sat;
            steps_d = steps_q + CW'(1);
            state_d = S_RD;
          end
        end else if (!merge_q) begin
          if (!in_use) begin
            status_d = tnfa_pkg::ST_BAD_HEADER;
            state_d  = S_DONE;
          end else begin
            chk_d   = rd_chk;
            merge_d = 1'b1;
            off_d   = end_sat;
            steps_d = '0;
            state_d = S_RD;
          end
        end else if (in_use) begin
          state_d = S_MRGWR;
        end else begin
          off_d   = end_sat;
          steps_d = steps_q + CW'(1);
          state_d = S_RD;
        end
      end
      S_HASHN: begin
        // hash of the new tag; fetch the split header to keep its check word
        hash_in   = 32'(hdr_q) ^ tag_q ^ key_q;
        prod_d    = hash_in * tnfa_pkg::HASH_MUL;
        mem_re    = 1'b1;
        mem_raddr = nend_q[AW-1:0];
        state_d   = S_WRA;
      end
      S_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_q[AW-1:0];
        mem_wdata = {(split_q ? nend_q : oend_q), tag_q, hash};
        status_d  = tnfa_pkg::ST_ALLOCATED;
        if (split_q) begin
          state_d = S_WRB;
        end else begin
          search_d = (oend_q >= cap_q) ? '0 : oend_q;
          state_d  = S_DONE;
        end
      end
      S_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = nend_q[AW-1:0];
        mem_wdata = {oend_q, 32'd0, rd_chk};
        search_d  = nend_q;
        state_d   = S_DONE;
      end
      S_MRGWR: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_q[AW-1:0];
        mem_wdata = {off_q, 32'd0, chk_q};
        if (search_q > hdr_q && search_q < off_q) begin
          search_d = hdr_q;
        end
        status_d = tnfa_pkg::ST_FREED;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {1'b0, data_q, status_q};
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cap_wr) begin
      cap_d    = cap_clamp;
      search_d = '0;
      clr_d    = '0;
      state_d  = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      key_q    <= '0;
      cap_q    <= OW'(RSTCAP);
      search_q <= '0;
      clr_q    <= '0;
      steps_q  <= '0;
      pass_q   <= 1'b0;
      merge_q  <= 1'b0;
      kind_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i && cfg_idx_i == tnfa_pkg::CFG_KEY) begin
        key_q <= cfg_data_i;
      end
      cap_q    <= cap_d;
      search_q <= search_d;
      clr_q    <= clr_d;
      steps_q  <= steps_d;
      pass_q   <= pass_d;
      merge_q  <= merge_d;
      kind_q   <= kind_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    tag_q    <= tag_d;
    off_q    <= off_d;
    hdr_q    <= hdr_d;
    nend_q   <= nend_d;
    oend_q   <= oend_d;
    split_q  <= split_d;
    chk_q    <= chk_d;
    prod_q   <= prod_d;
    status_q <= status_d;
    data_q   <= data_d;
    odata_q  <= odata_d;
  end

  `TNFA_ASSERT(a_cap_range, clk_i, rst_ni,
    (cap_q >= OW'(HEADER_BYTES)) && (cap_q <= OW'(POOL_BYTES)), "capacity out of range")
  `TNFA_ASSERT(a_search_below_cap, clk_i, rst_ni,
    search_q < cap_q, "search start at or past capacity")
  `TNFA_ASSERT(a_walk_bound, clk_i, rst_ni,
    steps_q <= LIM_C, "walk step count past limit")
  `TNFA_ASSERT_NEXT(a_clear_blocks, clk_i, rst_ni,
    cap_wr, !s_axis_tready, "request taken right after capacity write")

endmodule

`default_nettype wire
